[rtl/core/assert_macros.svh]
// assertion macros used by the banked register file top
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// implication whose consequent is checked on the next clock
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/core/brf_pkg.sv]
// constants and helpers for the banked register file
// no dependencies
package brf_pkg;
  localparam logic [3:0] OP_READ = 4'd0, OP_WRITE = 4'd1, OP_MODE = 4'd2, OP_IRQ = 4'd3,
    OP_SWI = 4'd4, OP_COND = 4'd5, OP_RSPSR = 4'd6, OP_WSPSR = 4'd7, OP_RESTART = 4'd8,
    OP_RCPSR = 4'd9;
  localparam logic [4:0] M_USR = 5'h10, M_FIQ = 5'h11, M_IRQ = 5'h12, M_SVC = 5'h13,
    M_ABT = 5'h17, M_UND = 5'h1B, M_SYS = 5'h1F;
  localparam logic [31:0] SP_USR_INIT = 32'h03007F00;
  localparam logic [31:0] SP_IRQ_INIT = 32'h03007FA0;
  localparam logic [31:0] SP_SVC_INIT = 32'h03007FE0;
  localparam logic [31:0] IRQ_PC = 32'h00000018 + 32'd8;
  localparam logic [31:0] SWI_PC = 32'h00000008 + 32'd8;
  localparam int FLAG_N = 31, FLAG_Z = 30, FLAG_C = 29, FLAG_V = 28, FLAG_I = 7, FLAG_T = 5;
  localparam int REG_ENTRY = 0, REG_THUMB = 1;
  localparam int MEM_AW = 6;
  localparam int MEM_DEPTH = 64;
  // memory map: 0..15 visible, 16..20 user r8-12, 24..28 fiq r8-12,
  // 32..37 sp slots, 40..45 lr slots, 48..52 saved status
  localparam logic [5:0] A_USRHI = 6'd16, A_FIQHI = 6'd24, A_SP = 6'd32, A_LR = 6'd40,
    A_SPSR = 6'd48;

  function automatic logic [2:0] sp_slot(input logic [4:0] m);
    case (m)
      M_USR, M_SYS: sp_slot = 3'd0;
      M_FIQ: sp_slot = 3'd1;
      M_IRQ: sp_slot = 3'd2;
      M_SVC: sp_slot = 3'd3;
      M_ABT: sp_slot = 3'd4;
      M_UND: sp_slot = 3'd5;
      default: sp_slot = 3'd7;
    endcase
  endfunction

  function automatic logic [2:0] spsr_slot(input logic [4:0] m);
    case (m)
      M_FIQ: spsr_slot = 3'd0;
      M_IRQ: spsr_slot = 3'd1;
      M_SVC: spsr_slot = 3'd2;
      M_ABT: spsr_slot = 3'd3;
      M_UND: spsr_slot = 3'd4;
      default: spsr_slot = 3'd7;
    endcase
  endfunction

  function automatic logic cond_holds(input logic [3:0] c, input logic [31:0] s);
    logic n, z, cf, v;
    n = s[FLAG_N]; z = s[FLAG_Z]; cf = s[FLAG_C]; v = s[FLAG_V];
    case (c)
      4'd0: cond_holds = z;
      4'd1: cond_holds = !z;
      4'd2: cond_holds = cf;
      4'd3: cond_holds = !cf;
      4'd4: cond_holds = n;
      4'd5: cond_holds = !n;
      4'd6: cond_holds = v;
      4'd7: cond_holds = !v;
      4'd8: cond_holds = cf && !z;
      4'd9: cond_holds = !cf || z;
      4'd10: cond_holds = n == v;
      4'd11: cond_holds = n != v;
      4'd12: cond_holds = !z && (n == v);
      4'd13: cond_holds = z || (n != v);
      4'd14: cond_holds = 1'b1;
      default: cond_holds = 1'b0;
    endcase
  endfunction
endpackage

[rtl/core/brf_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module brf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/banked_register_file_mode_control_top.sv]
// banked register file top level, built on brf_pkg, brf_ram and assert_macros.svh
// writes, cond ops, RCPSR and WSPSR go straight to S_DONE; reads and RSPSR pass S_WAIT;
// restart writes its words in S_COPY, and a mode switch or entry copies each word in S_COPY by a read then a write
// throughput: one request at a time, next accepted the cycle after the result is loaded
// reset: synchronous; a clearing pass zeroes every ram word, status word to system mode
`include "assert_macros.svh"
module banked_register_file_mode_control_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_value,
  input  logic [4:0]  target_mode,
  input  logic [3:0]  cond_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        cond_pass,
  output logic        exception_taken,
  output logic [4:0]  mode_now,
  output logic        thumb_now
);
  import brf_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_COPY = 3'd2, S_WAIT = 3'd3,
    S_DONE = 3'd4;
  // micro-op kinds: copy reads src then writes dst, wrc writes a constant to dst
  localparam logic [1:0] K_COPY = 2'd0, K_WRC = 2'd1;

  logic [2:0] state;
  logic [31:0] entry_address;
  logic start_in_thumb;
  logic [31:0] status_word;
  logic [3:0] op;
  logic [4:0] tmode;
  logic [5:0] clr;
  // micro-op program: step counter and phase
  logic [5:0] step;
  logic [31:0] old_status;
  logic [31:0] ret_addr;
  logic [1:0] phase;

  logic ram_we;
  logic [MEM_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  brf_ram #(.Width(32), .Depth(MEM_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // micro-op description for the current step
  logic        u_valid;
  logic [1:0]  u_kind;
  logic [5:0]  u_src, u_dst;
  logic [31:0] u_const;

  logic [4:0] om, nm;
  logic [2:0] os, ns;
  assign om = old_status[4:0];
  assign os = sp_slot(om);
  assign ns = sp_slot(nm);

  always_comb begin
    nm = tmode;
    if (op == OP_IRQ) nm = M_IRQ;
    if (op == OP_SWI) nm = M_SVC;
  end

  // steps 0..6 save old bank, 7..13 restore new bank, 14+ op specific
  always_comb begin
    u_valid = 1'b0;
    u_kind = K_COPY;
    u_src = '0;
    u_dst = '0;
    u_const = '0;
    if (step < 6'd7) begin
      if (os != 3'd7 && om != nm) begin
        u_valid = 1'b1;
        if (step < 6'd5) begin
          u_src = 6'd8 + step;
          u_dst = ((om == M_FIQ) ? A_FIQHI : A_USRHI) + step;
        end else if (step == 6'd5) begin
          u_src = 6'd13;
          u_dst = A_SP + {3'd0, os};
        end else begin
          u_src = 6'd14;
          u_dst = A_LR + {3'd0, os};
        end
      end
    end else if (step < 6'd14) begin
      if (om != nm) begin
        if (step < 6'd12) begin
          u_valid = 1'b1;
          u_src = ((nm == M_FIQ) ? A_FIQHI : A_USRHI) + (step - 6'd7);
          u_dst = 6'd8 + (step - 6'd7);
        end else if (ns != 3'd7) begin
          u_valid = 1'b1;
          u_src = (step == 6'd12) ? (A_SP + {3'd0, ns}) : (A_LR + {3'd0, ns});
          u_dst = (step == 6'd12) ? 6'd13 : 6'd14;
        end
      end
    end else if (op == OP_IRQ || op == OP_SWI) begin
      u_kind = K_WRC;
      u_valid = step < 6'd18;
      case (step)
        6'd14: begin
          u_dst = A_SPSR + {3'd0, spsr_slot(nm)};
          u_const = old_status;
        end
        6'd15: begin u_dst = 6'd14; u_const = ret_addr; end
        6'd16: begin u_dst = A_LR + {3'd0, ns}; u_const = ret_addr; end
        6'd17: begin u_dst = 6'd15; u_const = (op == OP_IRQ) ? IRQ_PC : SWI_PC; end
        default: ;
      endcase
    end
  end

  logic [31:0] restart_pc;
  assign restart_pc = start_in_thumb ? ({entry_address[31:1], 1'b0} + 32'd4)
                                     : ({entry_address[31:2], 2'b00} + 32'd8);

  logic spsr_banked;
  assign spsr_banked = spsr_slot(status_word[4:0]) != 3'd7;

  assign in_stall = (state != S_IDLE);
  logic accept;
  assign accept = in_valid && !in_stall;
  logic out_take;
  assign out_take = out_valid && !out_stall;
  logic done_load;
  assign done_load = (state == S_DONE) && (!out_valid || out_take);

  // ram port control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_CLEAR: begin ram_we = 1'b1; ram_waddr = clr; end
      S_IDLE: begin
        ram_raddr = {2'b00, reg_index};
        if (opcode == OP_RSPSR) ram_raddr = A_SPSR + {3'd0, spsr_slot(status_word[4:0])};
        // return address source
        if (opcode == OP_IRQ || opcode == OP_SWI) ram_raddr = 6'd15;
        if (accept) begin
          if (opcode == OP_WRITE) begin
            ram_we = 1'b1; ram_waddr = {2'b00, reg_index}; ram_wdata = write_value;
          end else if (opcode == OP_WSPSR && spsr_banked) begin
            ram_we = 1'b1; ram_waddr = A_SPSR + {3'd0, spsr_slot(status_word[4:0])};
            ram_wdata = write_value;
          end
        end
      end
      S_COPY: begin
        if (op == OP_RESTART) begin
          ram_we = 1'b1;
          case (step)
            6'd0: begin ram_waddr = A_SP; ram_wdata = SP_USR_INIT; end
            6'd1: begin ram_waddr = A_SP + 6'd2; ram_wdata = SP_IRQ_INIT; end
            6'd2: begin ram_waddr = A_SP + 6'd3; ram_wdata = SP_SVC_INIT; end
            6'd3: begin ram_waddr = 6'd13; ram_wdata = SP_USR_INIT; end
            default: begin ram_waddr = 6'd15; ram_wdata = restart_pc; end
          endcase
        end else if (u_valid) begin
          if (u_kind == K_WRC) begin
            ram_we = 1'b1; ram_waddr = u_dst; ram_wdata = u_const;
          end else if (phase == 2'd0) begin
            ram_raddr = u_src;
          end else begin
            ram_we = 1'b1; ram_waddr = u_dst; ram_wdata = ram_rdata;
          end
        end
      end
      default: ;
    endcase
  end

  logic [31:0] result;
  logic        result_pass, result_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      entry_address <= '0;
      start_in_thumb <= 1'b0;
      status_word <= {27'd0, M_SYS};
      out_valid <= 1'b0;
      step <= '0;
      phase <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(REG_ENTRY)) entry_address <= cfg_data;
        else start_in_thumb <= cfg_data[0];
      end
      if (done_load) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 6'd1;
          if (clr == 6'(MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op <= opcode; tmode <= target_mode;
            old_status <= status_word;
            step <= '0; phase <= '0;
            result <= '0; result_pass <= 1'b0; result_taken <= 1'b0;
            case (opcode)
              OP_READ, OP_RSPSR: state <= S_WAIT;
              OP_COND: begin result_pass <= cond_holds(cond_code, status_word); state <= S_DONE; end
              OP_WSPSR: begin
                if (!spsr_banked) status_word <= write_value;
                state <= S_DONE;
              end
              OP_RCPSR: begin result <= status_word; state <= S_DONE; end
              OP_MODE: state <= S_COPY;
              OP_RESTART: begin
                status_word <= {26'd0, start_in_thumb, M_SYS};
                state <= S_COPY;
              end
              OP_IRQ: begin
                if (status_word[FLAG_I]) state <= S_DONE;
                else state <= S_WAIT;
              end
              OP_SWI: state <= S_WAIT;
              default: state <= S_DONE;
            endcase
          end
        end
        S_WAIT: begin
          if (op == OP_IRQ || op == OP_SWI) begin
            ret_addr <= ram_rdata - (old_status[FLAG_T] ? ((op == OP_SWI) ? 32'd2 : 32'd0)
                                                         : 32'd4);
            state <= S_COPY;
          end else begin
            if (op == OP_RSPSR && !spsr_banked) result <= status_word;
            else result <= ram_rdata;
            state <= S_DONE;
          end
        end
        S_COPY: begin
          if (op == OP_RESTART) begin
            step <= step + 6'd1;
            if (step == 6'd4) begin result <= restart_pc; state <= S_DONE; end
          end else if (u_valid && u_kind == K_COPY && phase == 2'd0) begin
            phase <= 2'd1;
          end else begin
            phase <= 2'd0;
            step <= step + 6'd1;
            if (step == 6'd13) status_word <= {status_word[31:5], nm};
            if (step == 6'd18 || (step == 6'd13 && op == OP_MODE)) begin
              if (op != OP_MODE) begin
                status_word[FLAG_I] <= 1'b1;
                status_word[FLAG_T] <= 1'b0;
                result <= (op == OP_IRQ) ? IRQ_PC : SWI_PC;
                result_taken <= 1'b1;
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (done_load) begin
            read_data <= result;
            cond_pass <= result_pass;
            exception_taken <= result_taken;
            mode_now <= status_word[4:0];
            thumb_now <= status_word[FLAG_T];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, !accept)
  `CHK_NEXT(a_done_to_out, clk, rst, state == S_DONE && !out_valid, out_valid)
  `CHK_IMPL(a_clear_no_out, clk, rst, state == S_CLEAR, !out_valid)
endmodule

[test/banked_register_file_mode_control_top_tb.sv]
// testbench for the banked register file with mode control and exception entry
// depends on brf_pkg and banked_register_file_mode_control_top; self-checking,
// with its own bank and status model, a directed table, then random phases
`timescale 1ns / 1ps
module banked_register_file_mode_control_top_tb;
  import brf_pkg::*;

  typedef struct packed {
    logic [31:0] rd;
    logic        pass;
    logic        taken;
    logic [4:0]  mode;
    logic        thumb;
  } reg_result_t;

  typedef struct {
    logic [3:0]  op;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [4:0]  tm;
    logic [3:0]  cc;
    bit          typed;
    reg_result_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  opcode = '0;
  logic [3:0]  reg_index = '0;
  logic [31:0] write_value = '0;
  logic [4:0]  target_mode = '0;
  logic [3:0]  cond_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        cond_pass;
  logic        exception_taken;
  logic [4:0]  mode_now;
  logic        thumb_now;

  banked_register_file_mode_control_top dut (.*);

  always #4 clk = ~clk;

  // model copy of the register banks
  logic [31:0] vregs [16];
  logic [31:0] usr_hi [5];
  logic [31:0] fiq_hi [5];
  logic [31:0] sp_bank [6];
  logic [31:0] lr_bank [6];
  logic [31:0] spsr_bank [5];
  logic [31:0] cpsr;
  logic [31:0] entry_pc;
  logic        boot_thumb;

  reg_result_t pending_results [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit pressure_on = 0;
  int pressure_count = 0;
  int accepted = 0;
  int entries_taken = 0;

  localparam logic [4:0] MODE_LIST [7] = '{M_USR, M_FIQ, M_IRQ, M_SVC, M_ABT, M_UND, M_SYS};

  function automatic int bank_slot(logic [4:0] m);
    case (m)
      M_USR, M_SYS: return 0;
      M_FIQ: return 1;
      M_IRQ: return 2;
      M_SVC: return 3;
      M_ABT: return 4;
      M_UND: return 5;
      default: return -1;
    endcase
  endfunction

  function automatic int spsr_index(logic [4:0] m);
    case (m)
      M_FIQ: return 0;
      M_IRQ: return 1;
      M_SVC: return 2;
      M_ABT: return 3;
      M_UND: return 4;
      default: return -1;
    endcase
  endfunction

  function automatic logic [31:0] spsr_get();
    int s;
    s = spsr_index(cpsr[4:0]);
    return (s < 0) ? cpsr : spsr_bank[s];
  endfunction

  function automatic void spsr_put(logic [31:0] v);
    int s;
    s = spsr_index(cpsr[4:0]);
    if (s < 0) cpsr = v;
    else spsr_bank[s] = v;
  endfunction

  function automatic void switch_bank(logic [4:0] nm);
    logic [4:0] om;
    int s;
    om = cpsr[4:0];
    if (om == nm) return;
    s = bank_slot(om);
    if (s >= 0) begin
      for (int k = 0; k < 5; k++) begin
        if (om == M_FIQ) fiq_hi[k] = vregs[8 + k];
        else usr_hi[k] = vregs[8 + k];
      end
      sp_bank[s] = vregs[13];
      lr_bank[s] = vregs[14];
    end
    for (int k = 0; k < 5; k++) vregs[8 + k] = (nm == M_FIQ) ? fiq_hi[k] : usr_hi[k];
    s = bank_slot(nm);
    if (s >= 0) begin
      vregs[13] = sp_bank[s];
      vregs[14] = lr_bank[s];
    end
    cpsr[4:0] = nm;
  endfunction

  function automatic logic cond_met(logic [3:0] c);
    logic n, z, cf, v;
    n = cpsr[FLAG_N]; z = cpsr[FLAG_Z]; cf = cpsr[FLAG_C]; v = cpsr[FLAG_V];
    case (c)
      4'd0: return z;
      4'd1: return !z;
      4'd2: return cf;
      4'd3: return !cf;
      4'd4: return n;
      4'd5: return !n;
      4'd6: return v;
      4'd7: return !v;
      4'd8: return cf && !z;
      4'd9: return !cf || z;
      4'd10: return n == v;
      4'd11: return n != v;
      4'd12: return !z && (n == v);
      4'd13: return z || (n != v);
      4'd14: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] enter_exception(logic [4:0] m, logic [31:0] thumb_back,
                                                  logic [31:0] new_pc);
    logic [31:0] old, ret;
    old = cpsr;
    ret = vregs[15] - (old[FLAG_T] ? thumb_back : 32'd4);
    switch_bank(m);
    spsr_put(old);
    vregs[14] = ret;
    lr_bank[bank_slot(m)] = ret;
    cpsr[FLAG_I] = 1'b1;
    cpsr[FLAG_T] = 1'b0;
    vregs[15] = new_pc;
    return new_pc;
  endfunction

  function automatic reg_result_t predict_access(logic [3:0] op, logic [3:0] idx,
                                                 logic [31:0] val, logic [4:0] tm,
                                                 logic [3:0] cc);
    reg_result_t r;
    r = '0;
    case (op)
      OP_READ: r.rd = vregs[idx];
      OP_WRITE: vregs[idx] = val;
      OP_MODE: switch_bank(tm);
      OP_IRQ: if (!cpsr[FLAG_I]) begin
        r.rd = enter_exception(M_IRQ, 32'd0, IRQ_PC);
        r.taken = 1'b1;
      end
      OP_SWI: begin
        r.rd = enter_exception(M_SVC, 32'd2, SWI_PC);
        r.taken = 1'b1;
      end
      OP_COND: r.pass = cond_met(cc);
      OP_RSPSR: r.rd = spsr_get();
      OP_WSPSR: spsr_put(val);
      OP_RESTART: begin
        cpsr = {26'd0, boot_thumb, M_SYS};
        sp_bank[0] = SP_USR_INIT;
        sp_bank[2] = SP_IRQ_INIT;
        sp_bank[3] = SP_SVC_INIT;
        vregs[13] = SP_USR_INIT;
        vregs[15] = boot_thumb ? (entry_pc & ~32'd1) + 32'd4 : (entry_pc & ~32'd3) + 32'd8;
        r.rd = vregs[15];
      end
      OP_RCPSR: r.rd = cpsr;
      default: ;
    endcase
    r.mode = cpsr[4:0];
    r.thumb = cpsr[FLAG_T];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result side: random stall, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (pressure_on && pressure_count < 400) begin
      pressure_count <= pressure_count + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    reg_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting", read_data, 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (read_data !== w.rd) report_mismatch("read_data", read_data, w.rd);
        if (cond_pass !== w.pass)
          report_mismatch("cond_pass", 32'(cond_pass), 32'(w.pass));
        if (exception_taken !== w.taken)
          report_mismatch("exception_taken", 32'(exception_taken), 32'(w.taken));
        if (mode_now !== w.mode) report_mismatch("mode_now", 32'(mode_now), 32'(w.mode));
        if (thumb_now !== w.thumb)
          report_mismatch("thumb_now", 32'(thumb_now), 32'(w.thumb));
      end
    end
  end

  task automatic send_request(logic [3:0] op, logic [3:0] idx, logic [31:0] val,
                              logic [4:0] tm, logic [3:0] cc, bit typed, reg_result_t want);
    reg_result_t r;
    in_valid <= 1'b1;
    opcode <= op;
    reg_index <= idx;
    write_value <= val;
    target_mode <= tm;
    cond_code <= cc;
    do @(posedge clk); while (in_stall);
    r = predict_access(op, idx, val, tm, cc);
    pending_results.push_back(typed ? want : r);
    accepted++;
    if (r.taken) entries_taken++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_and_configure(logic [31:0] pc, logic thumb);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 1'(REG_ENTRY);
    cfg_data <= pc;
    @(posedge clk);
    cfg_index <= 1'(REG_THUMB);
    cfg_data <= {31'd0, thumb};
    @(posedge clk);
    cfg_we <= 1'b0;
    entry_pc = pc;
    boot_thumb = thumb;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_mode();
    if ($urandom_range(99) < 80) return MODE_LIST[$urandom_range(6)];
    return 5'($urandom_range(31));
  endfunction

  task automatic send_random();
    logic [3:0] op;
    logic [31:0] val;
    int w;
    w = $urandom_range(99);
    if (w < 6) op = 4'($urandom_range(10, 15));
    else op = 4'($urandom_range(0, 9));
    val = pick_value();
    // saved status writes mostly carry a listed mode so the banks stay in play
    if (op == OP_WSPSR && $urandom_range(99) < 75) val[4:0] = MODE_LIST[$urandom_range(6)];
    send_request(op, 4'($urandom_range(15)), val, pick_mode(), 4'($urandom_range(15)),
                 0, '0);
  endtask

  table_row_t directed [$];

  function automatic table_row_t row(logic [3:0] op, logic [3:0] idx, logic [31:0] val,
                                     logic [4:0] tm, logic [3:0] cc, bit typed = 0,
                                     logic [31:0] rd = 0, logic [4:0] m = M_SYS);
    table_row_t t;
    t.op = op; t.idx = idx; t.val = val; t.tm = tm; t.cc = cc; t.typed = typed;
    t.want = '{rd: rd, pass: 1'b0, taken: 1'b0, mode: m, thumb: 1'b0};
    return t;
  endfunction

  initial begin
    #(8 * 800000);
    $display("timeout: results still outstanding");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int idle_set [6];
    int stall_set [6];
    logic [31:0] pc_set [6];
    for (int i = 0; i < 16; i++) vregs[i] = '0;
    for (int i = 0; i < 5; i++) begin
      usr_hi[i] = '0; fiq_hi[i] = '0; spsr_bank[i] = '0;
    end
    for (int i = 0; i < 6; i++) begin
      sp_bank[i] = '0; lr_bank[i] = '0;
    end
    cpsr = {27'd0, M_SYS};
    entry_pc = '0;
    boot_thumb = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(row(OP_RCPSR, 0, 0, 0, 0, 1, 32'h1F));
    directed.push_back(row(OP_READ, 15, 0, 0, 0, 1, 32'h0));
    directed.push_back(row(OP_WRITE, 8, 32'hFFFFFFFF, 0, 0, 1, 32'h0));
    directed.push_back(row(OP_WRITE, 13, 32'hA5A5A5A5, 0, 0, 1, 32'h0));
    directed.push_back(row(OP_MODE, 0, 0, M_FIQ, 0));
    directed.push_back(row(OP_READ, 8, 0, 0, 0));
    directed.push_back(row(OP_WRITE, 8, 32'h12345678, 0, 0));
    directed.push_back(row(OP_MODE, 0, 0, 5'h05, 0));          // unlisted mode
    directed.push_back(row(OP_MODE, 0, 0, 5'h05, 0));          // same mode again
    directed.push_back(row(OP_READ, 8, 0, 0, 0));
    directed.push_back(row(OP_RSPSR, 0, 0, 0, 0));
    directed.push_back(row(OP_WSPSR, 0, 32'hF00000D0, 0, 0));  // i set, user mode
    directed.push_back(row(OP_COND, 0, 0, 0, 4'd0));
    directed.push_back(row(OP_COND, 0, 0, 0, 4'd11));
    directed.push_back(row(OP_COND, 0, 0, 0, 4'd15));
    directed.push_back(row(OP_IRQ, 0, 0, 0, 0));                // masked
    directed.push_back(row(OP_SWI, 0, 0, 0, 0));
    directed.push_back(row(OP_RSPSR, 0, 0, 0, 0));
    directed.push_back(row(OP_MODE, 0, 0, M_SYS, 0));
    directed.push_back(row(OP_WSPSR, 0, 32'h0000003F, 0, 0));  // thumb, i clear
    directed.push_back(row(OP_IRQ, 0, 0, 0, 0));
    directed.push_back(row(OP_RSPSR, 0, 0, 0, 0));
    directed.push_back(row(OP_RESTART, 0, 0, 0, 0, 1, 32'h8));
    directed.push_back(row(OP_READ, 13, 0, 0, 0, 1, SP_USR_INIT));
    directed.push_back(row(4'd15, 0, 32'hFFFFFFFF, 5'h1F, 4'hF, 1, 32'h0));
    foreach (directed[i])
      send_request(directed[i].op, directed[i].idx, directed[i].val, directed[i].tm,
                   directed[i].cc, directed[i].typed, directed[i].want);

    idle_set = '{0, 67, 0, 17, 0, 67};
    stall_set = '{0, 0, 67, 17, 0, 67};
    pc_set = '{32'h0, 32'hFFFFFFFF, 32'h08000000, 32'h0, 32'hFFFFFFFF, 32'h0};
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_configure(ph == 2 ? $urandom : pc_set[ph], ph[0]);
      send_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 4) pressure_on = 1;
      for (int n = 0; n < 270; n++) begin
        // restart every so often to get fresh stack pointers and the entry point
        if (n % 60 == 0) send_request(OP_RESTART, 0, 0, 0, 0, 0, '0);
        else send_random();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d requests over six idle/stall phases, %0d exception entries",
             accepted, entries_taken);
    $display("entry point and start state changed between phases, one long output hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[banked_register_file_mode_control_top.f]
+incdir+rtl/core
rtl/core/brf_pkg.sv
rtl/core/brf_ram.sv
rtl/core/banked_register_file_mode_control_top.sv
test/banked_register_file_mode_control_top_tb.sv
